@@ rtl/atoc_pkg.sv @@
// Shared types and constants for the alpha tile occupancy classifier.
// Depends on nothing; every other file of the block but atoc_checker imports it.
package atoc_pkg;

  // Geometry: 32x32 tiles split into 16x16 quadrants
  localparam int unsigned MAX_TILES_X = 64;
  localparam int unsigned TILE_LG     = 5;
  localparam int unsigned SUB_SIDE    = 16;
  localparam int unsigned PIX_W       = 11;
  localparam int unsigned TX_W        = 6;
  localparam int unsigned POS_W       = 17;
  localparam int unsigned QUEUE_DEPTH = 4;

  // Register indexes on the configuration port
  localparam logic [2:0] CFG_MIN_ALPHA    = 3'd0;
  localparam logic [2:0] CFG_WIDTH_TILES  = 3'd1;
  localparam logic [2:0] CFG_HEIGHT_TILES = 3'd2;
  localparam logic [2:0] CFG_ORIGIN_X     = 3'd3;
  localparam logic [2:0] CFG_ORIGIN_Y     = 3'd4;

  // Clamp limits for the tile counts
  localparam logic [6:0] TILES_MIN = 7'd1;
  localparam logic [6:0] TILES_MAX = 7'd64;

  // Quadrant flag codes
  localparam logic [3:0] QUAD_NONE = 4'h0;
  localparam logic [3:0] QUAD_ALL  = 4'hF;

  typedef struct packed {
    logic [7:0]  min_alpha;
    logic [6:0]  width_tiles;
    logic [6:0]  height_tiles;
    logic [15:0] origin_x;
    logic [15:0] origin_y;
  } atoc_cfg_t;

  // One finished tile with at least one occupied quadrant
  typedef struct packed {
    logic [3:0]       flags;
    logic [POS_W-1:0] bx;
    logic [POS_W-1:0] by;
  } atoc_tile_t;

  // Clamp a tile count to 1..64 and scale it to pixels
  function automatic logic [PIX_W:0] tiles_to_px(input logic [6:0] tiles);
    logic [6:0] eff;
    begin
      if (tiles == 7'd0) begin
        eff = TILES_MIN;
      end else if (tiles > TILES_MAX) begin
        eff = TILES_MAX;
      end else begin
        eff = tiles;
      end
      tiles_to_px = {eff, 5'd0};
    end
  endfunction

endpackage

@@ rtl/atoc_front.sv @@
// Front part: pixel position counters, per-column quadrant flag memory and
// tile classification. Depends on atoc_pkg; feeds finished tiles to atoc_queue.
module atoc_front
  import atoc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  atoc_cfg_t  cfg,
  input  logic       in_tvalid,
  output logic       in_tready,
  input  logic [7:0] in_alpha,
  input  logic       in_start,
  output logic       push,
  output atoc_tile_t push_tile,
  input  logic       q_full
);

  // Position counters
  logic [PIX_W-1:0] col_r, row_r, col_nxt, row_nxt;

  // Stage one registers
  logic            s1_v_r;
  logic [TX_W-1:0] s1_tx_r;
  logic [TX_W-1:0] s1_ty_r;
  logic            s1_start_r;
  logic            s1_tstart_r;
  logic            s1_tend_r;
  logic [3:0]      s1_hit_r;
  logic [3:0]      mem_q_r;

  // Flag memory, its valid bits and the last-write bypass
  logic [3:0]       flag_mem [MAX_TILES_X];
  logic [MAX_TILES_X-1:0] valid_r, valid_nxt;
  logic             byp_v_r;
  logic [TX_W-1:0]  byp_tx_r;
  logic [3:0]       byp_data_r;

  logic [PIX_W:0]   wpx, hpx;
  logic [PIX_W-1:0] col0, row0, col1, row2;
  logic [PIX_W:0]   row1, colp, rowp;
  logic [TX_W-1:0]  tx_a;
  logic [4:0]       lx, ly;
  logic [3:0]       hit_a;
  logic             in_acc;
  logic             byp_hit;
  logic [3:0]       old_f, new_f;
  logic             s1_go;

  // Locate the incoming pixel and work out the counters after it
  always_comb begin
    wpx  = tiles_to_px(cfg.width_tiles);
    hpx  = tiles_to_px(cfg.height_tiles);
    col0 = in_start ? '0 : col_r;
    row0 = in_start ? '0 : row_r;
    if ({1'b0, col0} >= wpx) begin
      col1 = '0;
      row1 = {1'b0, row0} + 12'd1;
    end else begin
      col1 = col0;
      row1 = {1'b0, row0};
    end
    row2 = (row1 >= hpx) ? '0 : row1[PIX_W-1:0];
    tx_a = col1[PIX_W-1:TILE_LG];
    lx   = col1[TILE_LG-1:0];
    ly   = row2[TILE_LG-1:0];
    hit_a = '0;
    if (in_alpha >= cfg.min_alpha) begin
      hit_a[{ly[4], lx[4]}] = 1'b1;
    end
    colp = {1'b0, col1} + 12'd1;
    rowp = {1'b0, row2} + 12'd1;
    if (colp >= wpx) begin
      col_nxt = '0;
      row_nxt = (rowp >= hpx) ? '0 : rowp[PIX_W-1:0];
    end else begin
      col_nxt = colp[PIX_W-1:0];
      row_nxt = row2;
    end
  end

  // Merge the stored flags with this pixel
  always_comb begin
    byp_hit = byp_v_r && (byp_tx_r == s1_tx_r);
    if (s1_start_r) begin
      old_f = QUAD_NONE;
    end else if (byp_hit) begin
      old_f = byp_data_r;
    end else if (valid_r[s1_tx_r]) begin
      old_f = mem_q_r;
    end else begin
      old_f = QUAD_NONE;
    end
    new_f = (s1_tstart_r ? QUAD_NONE : old_f) | s1_hit_r;
    push  = s1_v_r && s1_tend_r && (new_f != QUAD_NONE);
    s1_go = s1_v_r && !(push && q_full);
    // drop all columns on an image start, then mark the written one
    valid_nxt = s1_start_r ? '0 : valid_r;
    valid_nxt[s1_tx_r] = 1'b1;
  end

  assign in_tready = !s1_v_r || s1_go;
  assign in_acc    = in_tvalid && in_tready;

  // Tile result: origin plus tile offset
  assign push_tile.flags = new_f;
  assign push_tile.bx = {cfg.origin_x[15], cfg.origin_x} + {6'd0, s1_tx_r, 5'd0};
  assign push_tile.by = {cfg.origin_y[15], cfg.origin_y} + {6'd0, s1_ty_r, 5'd0};

  // Advance counters and stage one control
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      col_r   <= '0;
      row_r   <= '0;
      s1_v_r  <= 1'b0;
      valid_r <= '0;
      byp_v_r <= 1'b0;
    end else begin
      if (in_acc) begin
        col_r <= col_nxt;
        row_r <= row_nxt;
      end
      s1_v_r <= in_acc || (s1_v_r && !s1_go);
      if (s1_go) begin
        valid_r <= valid_nxt;
        byp_v_r <= 1'b1;
      end
    end
  end

  // Stage one payload and flag memory access
  always_ff @(posedge clk) begin
    if (in_acc) begin
      s1_tx_r     <= tx_a;
      s1_ty_r     <= row2[PIX_W-1:TILE_LG];
      s1_start_r  <= in_start;
      s1_tstart_r <= (lx == 5'd0) && (ly == 5'd0);
      s1_tend_r   <= (lx == 5'd31) && (ly == 5'd31);
      s1_hit_r    <= hit_a;
      mem_q_r     <= flag_mem[tx_a];
    end
    if (s1_go) begin
      flag_mem[s1_tx_r] <= new_f;
      byp_tx_r          <= s1_tx_r;
      byp_data_r        <= new_f;
    end
  end

endmodule

@@ rtl/atoc_queue.sv @@
// Short tile queue between the classifying front and the node emitter.
// Depends on atoc_pkg for the tile record and the depth.
module atoc_queue
  import atoc_pkg::*;
(
  input  logic       clk,
  input  logic       rst_n,
  input  logic       push,
  input  atoc_tile_t push_tile,
  input  logic       pop,
  output atoc_tile_t head,
  output logic       empty,
  output logic       full
);

  localparam int unsigned PTR_W = $clog2(QUEUE_DEPTH);

  atoc_tile_t       slot_r [QUEUE_DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [PTR_W:0]   count_r;
  logic             do_push, do_pop;

  assign empty   = (count_r == '0);
  assign full    = (count_r == (PTR_W+1)'(QUEUE_DEPTH));
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign head    = slot_r[rd_ptr_r];

  // Advance pointers and occupancy
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (do_push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (do_pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      if (do_push && !do_pop) begin
        count_r <= count_r + 1'b1;
      end else if (do_pop && !do_push) begin
        count_r <= count_r - 1'b1;
      end
    end
  end

  // Store the pushed tile
  always_ff @(posedge clk) begin
    if (do_push) begin
      slot_r[wr_ptr_r] <= push_tile;
    end
  end

endmodule

@@ rtl/atoc_back.sv @@
// Back part: expands one queued tile into a large node or up to four
// quadrant nodes and drives the registered result stream. Depends on atoc_pkg.
module atoc_back
  import atoc_pkg::*;
(
  input  logic             clk,
  input  logic             rst_n,
  input  atoc_tile_t       head,
  input  logic             q_empty,
  output logic             pop,
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [POS_W-1:0] out_pos_x,
  output logic [POS_W-1:0] out_pos_y,
  output logic             out_is_large,
  output logic             out_last
);

  // Tile being expanded
  logic             w_v_r;
  logic [3:0]       w_flags_r;
  logic             w_large_r;
  logic [POS_W-1:0] w_bx_r, w_by_r;

  // Output register
  logic             o_v_r;
  logic [POS_W-1:0] o_x_r, o_y_r;
  logic             o_large_r, o_last_r;

  logic             load_out, w_done;
  logic [1:0]       q_sel;
  logic [3:0]       rem;
  logic             node_last;
  logic [POS_W-1:0] node_x, node_y;

  // Pick the lowest occupied quadrant still to emit
  always_comb begin
    if (w_flags_r[0]) begin
      q_sel = 2'd0;
    end else if (w_flags_r[1]) begin
      q_sel = 2'd1;
    end else if (w_flags_r[2]) begin
      q_sel = 2'd2;
    end else begin
      q_sel = 2'd3;
    end
    rem       = w_flags_r & (w_flags_r - 4'd1);
    node_last = w_large_r || (rem == QUAD_NONE);
    node_x    = w_bx_r + ((q_sel[0] && !w_large_r) ? POS_W'(SUB_SIDE) : '0);
    node_y    = w_by_r + ((q_sel[1] && !w_large_r) ? POS_W'(SUB_SIDE) : '0);
    load_out  = w_v_r && (!o_v_r || out_tready);
    w_done    = load_out && node_last;
    pop       = !q_empty && (!w_v_r || w_done);
  end

  // Hold or refill the working tile and the output register
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      w_v_r <= 1'b0;
      o_v_r <= 1'b0;
    end else begin
      if (pop) begin
        w_v_r <= 1'b1;
      end else if (w_done) begin
        w_v_r <= 1'b0;
      end
      if (load_out) begin
        o_v_r <= 1'b1;
      end else if (out_tready) begin
        o_v_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (pop) begin
      w_flags_r <= head.flags;
      w_large_r <= (head.flags == QUAD_ALL);
      w_bx_r    <= head.bx;
      w_by_r    <= head.by;
    end else if (load_out) begin
      w_flags_r <= rem;
    end
    if (load_out) begin
      o_x_r     <= node_x;
      o_y_r     <= node_y;
      o_large_r <= w_large_r;
      o_last_r  <= node_last;
    end
  end

  assign out_tvalid   = o_v_r;
  assign out_pos_x    = o_x_r;
  assign out_pos_y    = o_y_r;
  assign out_is_large = o_large_r;
  assign out_last     = o_last_r;

endmodule

@@ rtl/alpha_tile_occupancy_classifier_unit.sv @@
// Top level of the alpha tile occupancy classifier: configuration registers,
// front classifier, tile queue and node emitter. Depends on atoc_pkg.
//
// Takes one alpha pixel per clock in raster order over a padded image of
// 32x32 tiles and, at each tile's bottom-right pixel, queues the tile's
// occupied quadrants; the back end then sends one node per clock while
// out_tready is high (a large node, or up to four quadrant nodes in order
// top-left, top-right, bottom-left, bottom-right, tlast on the tile's
// final node). The input rate is one pixel per cycle: a two-step
// read-modify-write of the 64-entry quadrant flag memory with a last-write
// bypass sets it. Input stalls only when a tile finishes while the
// four-tile queue is full. Flags clear at once on reset and on
// start_of_image through per-column valid bits, so no clearing pass is
// needed. Write configuration only while the block is idle.
module alpha_tile_occupancy_classifier_unit
  import atoc_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  // Pixel stream
  input  logic        in_tvalid,
  output logic        in_tready,
  input  logic [7:0]  in_tdata,   // [7:0] alpha
  input  logic        in_tuser,   // [0] start_of_image
  // Node stream
  output logic        out_tvalid,
  input  logic        out_tready,
  output logic [39:0] out_tdata,  // [16:0] pos_x, [33:17] pos_y, [39:34] zero
  output logic        out_tuser,  // [0] is_large
  output logic        out_tlast,
  // Configuration
  input  logic        cfg_we,
  input  logic [2:0]  cfg_addr,
  input  logic [15:0] cfg_wdata
);

  atoc_cfg_t        cfg_r;
  atoc_tile_t       push_tile, head;
  logic             push, pop, q_empty, q_full;
  logic [POS_W-1:0] pos_x, pos_y;

  // Register configuration writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.min_alpha    <= 8'd1;
      cfg_r.width_tiles  <= TILES_MIN;
      cfg_r.height_tiles <= TILES_MIN;
      cfg_r.origin_x     <= '0;
      cfg_r.origin_y     <= '0;
    end else if (cfg_we) begin
      case (cfg_addr)
        CFG_MIN_ALPHA:    cfg_r.min_alpha    <= cfg_wdata[7:0];
        CFG_WIDTH_TILES:  cfg_r.width_tiles  <= cfg_wdata[6:0];
        CFG_HEIGHT_TILES: cfg_r.height_tiles <= cfg_wdata[6:0];
        CFG_ORIGIN_X:     cfg_r.origin_x     <= cfg_wdata;
        CFG_ORIGIN_Y:     cfg_r.origin_y     <= cfg_wdata;
        default: begin
        end
      endcase
    end
  end

  atoc_front u_front (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg       (cfg_r),
    .in_tvalid (in_tvalid),
    .in_tready (in_tready),
    .in_alpha  (in_tdata),
    .in_start  (in_tuser),
    .push      (push),
    .push_tile (push_tile),
    .q_full    (q_full)
  );

  atoc_queue u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (push),
    .push_tile (push_tile),
    .pop       (pop),
    .head      (head),
    .empty     (q_empty),
    .full      (q_full)
  );

  atoc_back u_back (
    .clk          (clk),
    .rst_n        (rst_n),
    .head         (head),
    .q_empty      (q_empty),
    .pop          (pop),
    .out_tvalid   (out_tvalid),
    .out_tready   (out_tready),
    .out_pos_x    (pos_x),
    .out_pos_y    (pos_y),
    .out_is_large (out_tuser),
    .out_last     (out_tlast)
  );

  assign out_tdata = {6'd0, pos_y, pos_x};

endmodule

@@ rtl/atoc_checker.sv @@
// Port-level checks for the alpha tile occupancy classifier, bound to the
// top level. Depends only on the top level's ports.
module atoc_checker (
  input logic        clk,
  input logic        rst_n,
  input logic        out_tvalid,
  input logic        out_tready,
  input logic [39:0] out_tdata,
  input logic        out_tuser,
  input logic        out_tlast
);

  // Hold a stalled node
  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && !out_tready |=> out_tvalid && $stable(out_tdata)
      && $stable(out_tuser) && $stable(out_tlast))
    else $error("stalled node changed");

  // A large node is always the only node of its tile
  a_large_last: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tuser |-> out_tlast)
    else $error("large node without tlast");

  // Quadrant nodes of one tile leave back to back
  a_tile_burst: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid && out_tready && !out_tlast |=> out_tvalid)
    else $error("gap inside a tile's nodes");

  // Reset drops any pending node
  a_reset_idle: assert property (@(posedge clk)
    !rst_n |=> !out_tvalid)
    else $error("node valid after reset");

endmodule

bind alpha_tile_occupancy_classifier_unit atoc_checker u_atoc_checker (
  .clk        (clk),
  .rst_n      (rst_n),
  .out_tvalid (out_tvalid),
  .out_tready (out_tready),
  .out_tdata  (out_tdata),
  .out_tuser  (out_tuser),
  .out_tlast  (out_tlast)
);
